// ----- hw/rtl/poi_pkg.sv -----
// shared constants and the cordic arctangent table for the planar odometry integrator
package poi_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam logic [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [32:0] TURN_SCALE = 33'd683565276;

    localparam logic [1:0] REQ_CMD     = 2'd0;
    localparam logic [1:0] REQ_TICK    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    localparam logic [1:0] CFG_START_X   = 2'd0;
    localparam logic [1:0] CFG_START_Y   = 2'd1;
    localparam logic [1:0] CFG_START_HDG = 2'd2;

    function automatic logic [33:0] atan_lut(input logic [4:0] idx);
        logic [33:0] v;
        unique case (idx)
            5'd0:  v = 34'h020000000;
            5'd1:  v = 34'h012E4051D;
            5'd2:  v = 34'h009FB385B;
            5'd3:  v = 34'h0051111D4;
            5'd4:  v = 34'h0028B0D43;
            5'd5:  v = 34'h00145D7E1;
            5'd6:  v = 34'h000A2F61E;
            5'd7:  v = 34'h000517C55;
            5'd8:  v = 34'h00028BE53;
            5'd9:  v = 34'h000145F2E;
            5'd10: v = 34'h0000A2F98;
            5'd11: v = 34'h0000517CC;
            5'd12: v = 34'h000028BE6;
            5'd13: v = 34'h0000145F3;
            5'd14: v = 34'h00000A2F9;
            5'd15: v = 34'h00000517C;
            5'd16: v = 34'h0000028BE;
            5'd17: v = 34'h00000145F;
            5'd18: v = 34'h000000A2F;
            5'd19: v = 34'h000000517;
            5'd20: v = 34'h00000028B;
            5'd21: v = 34'h000000145;
            5'd22: v = 34'h0000000A2;
            5'd23: v = 34'h000000051;
            5'd24: v = 34'h000000028;
            5'd25: v = 34'h000000014;
            5'd26: v = 34'h00000000A;
            5'd27: v = 34'h000000005;
            5'd28: v = 34'h000000002;
            5'd29: v = 34'h000000001;
            default: v = 34'h000000000;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/planar_odometry_integrator.sv -----
// planar dead-reckoning odometry integrator top level
// A command or restart transfer is absorbed directly in the idle state. A tick
// runs through two 30-step cordic passes (heading before the tick and half the
// heading after it) and eight products on one shift-add multiplier that retires
// one multiplier bit per cycle, each product after a load state. Input is taken
// only while no tick is in progress; a finished result may wait in the output
// register while the next commands are accepted, and the last cordic step of
// the next tick holds until that result has left.
module planar_odometry_integrator
    import poi_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // speed_x, speed_y, turn_rate, step_time
    input  logic [95:0]  s_axis_tdata,
    // req_type
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x, out_y, out_heading, quat_z, quat_w, used_speed_x, used_speed_y, used_turn_rate
    output logic [183:0] m_axis_tdata,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_ROT1, S_MUL_LOAD, S_MUL_RUN, S_ROT2
    } t_state;

    localparam int HSHIFT = 52 - ANGLE_BITS;

    t_state r_state;
    logic signed [31:0] r_start_x, r_start_y;
    logic [15:0] r_start_h;
    logic signed [31:0] r_px, r_py;
    logic [ANGLE_BITS-1:0] r_head;
    logic signed [23:0] r_vx, r_vy, r_w;
    logic [23:0] r_dt;

    logic signed [33:0] r_cx, r_cy, r_cz, r_c, r_s;
    logic r_neg;
    logic [4:0] r_ccnt;

    logic signed [63:0] r_acc, r_ma, r_sx, r_sy;
    logic signed [32:0] r_mb, r_r;
    logic [5:0] r_mcnt;
    logic [2:0] r_mstep;

    logic r_ovalid;
    logic [183:0] r_odata;

    // combinational helpers
    logic signed [33:0] n_cx, n_cy, n_cz, ys, xs, c_fin, s_fin;
    logic signed [63:0] op_a, n_acc, tmp64, sum64, satv;
    logic signed [32:0] op_b;
    logic [31:0] a32_1;
    logic [23:0] h24_in, h24_out;
    logic [ANGLE_BITS-1:0] head_restart, dstep;
    logic signed [34:0] qz_t, qw_t;
    logic signed [15:0] qz, qw;
    logic out_load;

    function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
        logic signed [34:0] t;
        t = (35'(v) + 35'sd16384) >>> 15;
        if (t > 35'sd32767) return 16'sd32767;
        if (t < -35'sd32768) return -16'sd32768;
        return t[15:0];
    endfunction

    always_comb begin
        h24_in = {r_start_h, 8'd0};
        head_restart = ANGLE_BITS'(h24_in >> (24 - ANGLE_BITS));
        h24_out = 24'(r_head) << (24 - ANGLE_BITS);
        a32_1 = 32'(r_head) << (32 - ANGLE_BITS);

        ys = r_cy >>> r_ccnt;
        xs = r_cx >>> r_ccnt;
        if (!r_cz[33]) begin
            n_cx = r_cx - ys;
            n_cy = r_cy + xs;
            n_cz = r_cz - atan_lut(r_ccnt);
        end else begin
            n_cx = r_cx + ys;
            n_cy = r_cy - xs;
            n_cz = r_cz + atan_lut(r_ccnt);
        end
        c_fin = r_neg ? -n_cx : n_cx;
        s_fin = r_neg ? -n_cy : n_cy;

        unique case (r_mstep)
            3'd0: begin op_a = 64'(r_vx); op_b = r_c[32:0]; end
            3'd1: begin op_a = 64'(r_vy); op_b = r_s[32:0]; end
            3'd2: begin op_a = 64'(r_vx); op_b = r_s[32:0]; end
            3'd3: begin op_a = 64'(r_vy); op_b = r_c[32:0]; end
            3'd4: begin op_a = r_sx >>> 30; op_b = {9'd0, r_dt}; end
            3'd5: begin op_a = r_sy >>> 30; op_b = {9'd0, r_dt}; end
            3'd6: begin op_a = 64'(r_w); op_b = {9'd0, r_dt}; end
            default: begin op_a = 64'(r_r); op_b = TURN_SCALE; end
        endcase

        if (!r_mb[0]) n_acc = r_acc;
        else if (r_mcnt == 6'd32) n_acc = r_acc - r_ma;
        else n_acc = r_acc + r_ma;

        tmp64 = n_acc >>> 20;
        sum64 = (r_mstep == 3'd4) ? 64'(r_px) + tmp64 : 64'(r_py) + tmp64;
        if (sum64 > 64'sd2147483647) satv = 64'sd2147483647;
        else if (sum64 < -64'sd2147483648) satv = -64'sd2147483648;
        else satv = sum64;
        dstep = ANGLE_BITS'(n_acc >>> HSHIFT);

        qz_t = 35'(s_fin);
        qw_t = 35'(c_fin);
        qz = to_q15(qz_t[33:0]);
        qw = to_q15(qw_t[33:0]);

        out_load = (r_state == S_ROT2) && (r_ccnt == 5'(CORDIC_STEPS - 1))
                   && (!r_ovalid || m_axis_tready);
    end

    function automatic logic signed [33:0] fold_z(input logic [31:0] a);
        logic signed [33:0] z;
        z = 34'(signed'(a));
        if (z > 34'sd1073741824) z = z - 34'sd2147483648;
        else if (z < -34'sd1073741824) z = z + 34'sd2147483648;
        return z;
    endfunction

    function automatic logic fold_neg(input logic [31:0] a);
        logic signed [33:0] z;
        z = 34'(signed'(a));
        return (z > 34'sd1073741824) || (z < -34'sd1073741824);
    endfunction

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_start_x <= '0;
            r_start_y <= '0;
            r_start_h <= '0;
            r_px      <= '0;
            r_py      <= '0;
            r_head    <= '0;
            r_vx      <= '0;
            r_vy      <= '0;
            r_w       <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_START_X:   r_start_x <= i_cfg_data;
                    CFG_START_Y:   r_start_y <= i_cfg_data;
                    CFG_START_HDG: r_start_h <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (out_load) r_ovalid <= 1'b1;
            else if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        unique case (s_axis_tuser)
                            REQ_CMD: begin
                                r_vx <= s_axis_tdata[23:0];
                                r_vy <= s_axis_tdata[47:24];
                                r_w  <= s_axis_tdata[71:48];
                            end
                            REQ_RESTART: begin
                                r_px   <= r_start_x;
                                r_py   <= r_start_y;
                                r_head <= head_restart;
                            end
                            REQ_TICK: begin
                                r_dt   <= s_axis_tdata[95:72];
                                r_cx   <= CORDIC_GAIN;
                                r_cy   <= '0;
                                r_cz   <= fold_z(a32_1);
                                r_neg  <= fold_neg(a32_1);
                                r_ccnt <= '0;
                                r_state <= S_ROT1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_ROT1, S_ROT2: begin
                    if (r_state == S_ROT1 || r_ccnt != 5'(CORDIC_STEPS - 1) || out_load) begin
                        r_cx   <= n_cx;
                        r_cy   <= n_cy;
                        r_cz   <= n_cz;
                        r_ccnt <= r_ccnt + 5'd1;
                        if (r_ccnt == 5'(CORDIC_STEPS - 1)) begin
                            if (r_state == S_ROT1) begin
                                r_c     <= c_fin;
                                r_s     <= s_fin;
                                r_mstep <= '0;
                                r_state <= S_MUL_LOAD;
                            end else begin
                                r_odata <= {r_w, r_vy, r_vx, qw, qz, h24_out[23:8], r_py, r_px};
                                r_vx    <= '0;
                                r_vy    <= '0;
                                r_w     <= '0;
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                S_MUL_LOAD: begin
                    r_acc   <= '0;
                    r_ma    <= op_a;
                    r_mb    <= op_b;
                    r_mcnt  <= '0;
                    r_state <= S_MUL_RUN;
                end
                S_MUL_RUN: begin
                    r_acc  <= n_acc;
                    r_ma   <= r_ma <<< 1;
                    r_mb   <= r_mb >>> 1;
                    r_mcnt <= r_mcnt + 6'd1;
                    if (r_mcnt == 6'd32) begin
                        unique case (r_mstep)
                            3'd0: r_sx <= n_acc;
                            3'd1: r_sx <= r_sx - n_acc;
                            3'd2: r_sy <= n_acc;
                            3'd3: r_sy <= r_sy + n_acc;
                            3'd4: r_px <= satv[31:0];
                            3'd5: r_py <= satv[31:0];
                            3'd6: r_r  <= 33'(n_acc >>> 16);
                            default: r_head <= r_head + dstep;
                        endcase
                        r_mstep <= r_mstep + 3'd1;
                        if (r_mstep == 3'd7) begin
                            r_cx    <= CORDIC_GAIN;
                            r_cy    <= '0;
                            r_cz    <= fold_z(32'(32'(r_head + dstep) << (32 - ANGLE_BITS)) >> 1);
                            r_neg   <= fold_neg(32'(32'(r_head + dstep) << (32 - ANGLE_BITS)) >> 1);
                            r_ccnt  <= '0;
                            r_state <= S_ROT2;
                        end else begin
                            r_state <= S_MUL_LOAD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
